### design/spt_pkg.sv
`default_nettype none
package spt_pkg;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_ADD    = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_EMPTY     = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_SUM_EMPTY = 3'd4;

    localparam int MAX_RESULTS = 32;

    typedef struct packed {
        logic [1:0]         operation;
        logic               which_poly;
        logic signed [15:0] exponent;
        logic signed [31:0] coefficient;
    } t_req;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [15:0] sum_exponent;
        logic signed [31:0] sum_coefficient;
        logic               last;
    } t_res;

    // saturating add of two q16.16 values
    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] s;
        s = {a[31], a} + {b[31], b};
        if (s[32] != s[31]) begin
            sat_add = s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
            sat_add = s[31:0];
        end
    endfunction

endpackage
`default_nettype wire

### design/spt_term_mem.sv
`default_nettype none
// term storage: one exponent/coefficient memory, one read port, one write port
module spt_term_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  wire logic                i_clk,
    input  wire logic                i_we,
    input  wire logic [AW-1:0]       i_waddr,
    input  wire logic signed [15:0]  i_wexp,
    input  wire logic signed [31:0]  i_wcoef,
    input  wire logic [AW-1:0]       i_raddr,
    output logic signed [15:0]       o_rexp,
    output logic signed [31:0]       o_rcoef
);
    logic [47:0] r_mem [DEPTH];
    logic [47:0] r_rd;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= {i_wexp, i_wcoef};
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[i_raddr];
    end

    assign o_rexp  = r_rd[47:32];
    assign o_rcoef = r_rd[31:0];
endmodule
`default_nettype wire

### design/sparse_polynomial_term_table.sv
`default_nettype none
// sparse polynomial term table
// holds two sorted term tables, A and B, in one synchronous memory
// (A in the lower MAX_TERMS slots, B in the upper).
// request channel: i_start with i_req is taken when o_busy is low.
// result channel: o_valid strobes o_res for one cycle; the receiver cannot
// stall, so results are never held back.
// insert/delete: one result, strobed in the cycle o_busy falls. the sequencer
// scans the table entry by entry (read, then compare), then shifts entries
// one at a time (read, then write). entries scanned plus entries shifted
// stay within the table size.
// add: per emitted term the sequencer reads the A head, reads the B head,
// then compares and emits; one result per term, last on the final one; at
// most min(2*MAX_TERMS, MAX_RESULTS) results. both empty gives one
// sum-empty result.
// operation code 3 is dropped with no result and o_busy stays low.
// reset clears both term counts; memory contents need no clearing.
module sparse_polynomial_term_table #(
    parameter int MAX_TERMS = 16
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire spt_pkg::t_req   i_req,
    output logic                 o_busy,
    output logic                 o_valid,
    output spt_pkg::t_res        o_res
);
    localparam int DEPTH = 2 * MAX_TERMS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(MAX_TERMS + 1);
    localparam int KW    = $clog2(spt_pkg::MAX_RESULTS + 1);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_SCAN  = 10'b0000000010,
        S_CHK   = 10'b0000000100,
        S_MRG   = 10'b0000001000,
        S_SHR   = 10'b0000010000,
        S_SHW   = 10'b0000100000,
        S_RDA   = 10'b0001000000,
        S_RDB   = 10'b0010000000,
        S_EMIT  = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } t_state;

    t_state r_state, n_state;
    logic [CW-1:0] r_cnt [2];
    logic [CW-1:0] n_cnt0, n_cnt1;
    spt_pkg::t_req r_req, n_req;
    logic [CW-1:0] r_i, n_i, r_j, n_j;
    logic [KW-1:0] r_k, n_k;
    logic signed [15:0] r_ea, n_ea;
    logic signed [31:0] r_ca, n_ca;
    logic r_valid, n_valid;
    spt_pkg::t_res r_res, n_res;

    logic              we;
    logic [AW-1:0]     waddr, raddr;
    logic signed [15:0] wexp, rexp;
    logic signed [31:0] wcoef, rcoef;

    spt_term_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wexp  (wexp),
        .i_wcoef (wcoef),
        .i_raddr (raddr),
        .o_rexp  (rexp),
        .o_rcoef (rcoef)
    );

    // slot address of entry idx in table p
    function automatic logic [AW-1:0] slot(input logic p, input logic [CW-1:0] idx);
        logic [AW:0] a;
        a = (AW+1)'(idx) + (p ? (AW+1)'(MAX_TERMS) : '0);
        slot = a[AW-1:0];
    endfunction

    logic [CW-1:0] sel_cnt;
    logic          a_left, b_left;
    assign sel_cnt = r_cnt[r_req.which_poly];
    assign a_left  = r_i < r_cnt[0];
    assign b_left  = r_j < r_cnt[1];

    // sequencer
    always_comb begin
        n_state = r_state;
        n_cnt0  = r_cnt[0];
        n_cnt1  = r_cnt[1];
        n_req   = r_req;
        n_i = r_i; n_j = r_j; n_k = r_k;
        n_ea = r_ea; n_ca = r_ca;
        n_valid = 1'b0;
        n_res   = '0;
        we = 1'b0; waddr = '0; wexp = '0; wcoef = '0;
        raddr = slot(r_req.which_poly, r_i);
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_req = i_req;
                    n_i = '0; n_j = '0; n_k = '0;
                    case (i_req.operation)
                        spt_pkg::OP_INSERT, spt_pkg::OP_DELETE: n_state = S_SCAN;
                        spt_pkg::OP_ADD: n_state = S_RDA;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            // issue read of entry r_i (or finish when past end)
            S_SCAN: begin
                raddr = slot(r_req.which_poly, r_i);
                if (r_i < sel_cnt) begin
                    n_state = S_CHK;
                end else begin
                    n_state = S_MRG;
                end
            end
            S_CHK: begin
                if (rexp < r_req.exponent) begin
                    n_i = r_i + 1'b1;
                    n_state = S_SCAN;
                end else begin
                    n_ea = rexp; n_ca = rcoef;
                    n_state = S_MRG;
                end
            end
            // decide at position r_i
            S_MRG: begin
                n_valid = 1'b1;
                n_res.last = 1'b1;
                n_state = S_IDLE;
                if (r_req.operation == spt_pkg::OP_INSERT) begin
                    if (r_i < sel_cnt && r_ea == r_req.exponent) begin
                        we = 1'b1; waddr = slot(r_req.which_poly, r_i);
                        wexp = r_ea; wcoef = spt_pkg::sat_add(r_ca, r_req.coefficient);
                        n_res.status = spt_pkg::ST_OK;
                    end else if (sel_cnt >= CW'(MAX_TERMS)) begin
                        n_res.status = spt_pkg::ST_FULL;
                    end else begin
                        // shift up from the top, r_j walks down
                        n_valid = 1'b0;
                        n_j = sel_cnt;
                        n_state = S_SHR;
                    end
                end else begin
                    if (sel_cnt == '0) begin
                        n_res.status = spt_pkg::ST_EMPTY;
                    end else if (!(r_i < sel_cnt) || r_ea != r_req.exponent) begin
                        n_res.status = spt_pkg::ST_NOT_FOUND;
                    end else begin
                        n_valid = 1'b0;
                        n_j = r_i;
                        n_state = S_SHR;
                    end
                end
            end
            // read source entry of one shift step, or end the shift (insert writes the new term) and update the count
            S_SHR: begin
                if (r_req.operation == spt_pkg::OP_INSERT) begin
                    if (r_j == r_i) begin
                        we = 1'b1; waddr = slot(r_req.which_poly, r_i);
                        wexp = r_req.exponent; wcoef = r_req.coefficient;
                        if (r_req.which_poly) n_cnt1 = r_cnt[1] + 1'b1;
                        else n_cnt0 = r_cnt[0] + 1'b1;
                        n_state = S_DONE;
                    end else begin
                        raddr = slot(r_req.which_poly, r_j - 1'b1);
                        n_state = S_SHW;
                    end
                end else begin
                    if (r_j + 1'b1 >= sel_cnt) begin
                        if (r_req.which_poly) n_cnt1 = r_cnt[1] - 1'b1;
                        else n_cnt0 = r_cnt[0] - 1'b1;
                        n_state = S_DONE;
                    end else begin
                        raddr = slot(r_req.which_poly, r_j + 1'b1);
                        n_state = S_SHW;
                    end
                end
            end
            S_SHW: begin
                we = 1'b1; waddr = slot(r_req.which_poly, r_j);
                wexp = rexp; wcoef = rcoef;
                if (r_req.operation == spt_pkg::OP_INSERT) n_j = r_j - 1'b1;
                else n_j = r_j + 1'b1;
                n_state = S_SHR;
            end
            S_DONE: begin
                n_valid = 1'b1;
                n_res.status = spt_pkg::ST_OK;
                n_res.last = 1'b1;
                n_state = S_IDLE;
            end
            // merge: fetch head of A then head of B; both empty gives a sum-empty result
            S_RDA: begin
                raddr = slot(1'b0, r_i);
                n_state = S_RDB;
                if (r_cnt[0] == '0 && r_cnt[1] == '0) begin
                    n_valid = 1'b1;
                    n_res.status = spt_pkg::ST_SUM_EMPTY;
                    n_res.last = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_RDB: begin
                raddr = slot(1'b1, r_j);
                n_ea = rexp; n_ca = rcoef;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                n_valid = 1'b1;
                n_res.status = spt_pkg::ST_OK;
                if (!b_left || (a_left && r_ea < rexp)) begin
                    n_res.sum_exponent = r_ea; n_res.sum_coefficient = r_ca;
                    n_i = r_i + 1'b1;
                end else if (!a_left || rexp < r_ea) begin
                    n_res.sum_exponent = rexp; n_res.sum_coefficient = rcoef;
                    n_j = r_j + 1'b1;
                end else begin
                    n_res.sum_exponent = r_ea;
                    n_res.sum_coefficient = spt_pkg::sat_add(r_ca, rcoef);
                    n_i = r_i + 1'b1;
                    n_j = r_j + 1'b1;
                end
                n_k = r_k + 1'b1;
                if ((n_i >= r_cnt[0] && n_j >= r_cnt[1])
                        || n_k >= KW'(spt_pkg::MAX_RESULTS)) begin
                    n_res.last = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_RDA;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt[0] <= '0;
            r_cnt[1] <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt[0] <= n_cnt0;
            r_cnt[1] <= n_cnt1;
            r_valid <= n_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_i <= n_i; r_j <= n_j; r_k <= n_k;
        r_ea <= n_ea; r_ca <= n_ca;
        r_res <= n_res;
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_res   = r_res;

    // counts never exceed capacity
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt[0] <= CW'(MAX_TERMS) && r_cnt[1] <= CW'(MAX_TERMS))
        else $error("term count overflow");
    // no shift starts from idle without a request
    a_idle_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !(i_start)) |=> !(r_state == S_SHW))
        else $error("shift without request");
    // counts change only at the end of an insert or delete
    a_cnt_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_SHR) |=> (r_cnt[0] == $past(r_cnt[0]) && r_cnt[1] == $past(r_cnt[1])))
        else $error("count changed outside shift");
endmodule
`default_nettype wire
